/* rtl/core/stc_pkg.sv */
`timescale 1ns / 1ps

package stc_pkg;

    // Geometry of one encoding.
    localparam int LANES       = 8;
    localparam int STRING_BITS = 8;
    localparam int LEVEL_BITS  = 4;

    // Fixed widths of the payload fields.
    localparam int BITS_W  = 64;
    localparam int LEVELS_W = 32;
    localparam int COUNT_W = 4;
    localparam int ORDER_W = 2;

    // The levels field is zero-extended so that every lane has a full slice.
    localparam int LEVEL_SPAN  = LANES * LEVEL_BITS;
    localparam int LEVEL_EXT_W = (LEVEL_SPAN > LEVELS_W) ? LEVEL_SPAN : LEVELS_W;

    // Result codes.
    localparam logic [ORDER_W-1:0] ORDER_LESS    = 2'd0;
    localparam logic [ORDER_W-1:0] ORDER_EQUAL   = 2'd1;
    localparam logic [ORDER_W-1:0] ORDER_GREATER = 2'd2;

    typedef logic [STRING_BITS-1:0] str_t;
    typedef logic [LEVEL_BITS-1:0]  level_t;

    // Everything one lane needs from both encodings.
    typedef struct packed {
        logic   present_a;
        logic   present_b;
        str_t   bits_a;
        str_t   mask_a;
        level_t level_a;
        str_t   bits_b;
        str_t   mask_b;
        level_t level_b;
    } lane_in_t;

    // What one lane found: whether it settles the order, and which way.
    typedef struct packed {
        logic decide;
        logic greater;
    } lane_result_t;

endpackage

/* rtl/core/strahler_tree_compare_unit.sv */
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// input     in_valid / in_ready    bits_a, prefixes_a, ranks_a, count_a,
//                                  bits_b, prefixes_b, ranks_b, count_b
// output    out_valid / out_ready  order
//
// A transfer can be accepted on every cycle while the output is not stalled; each
// comparison passes through the lane register and then the order register.
// The first stage registers the per-lane findings, the second stage registers
// the priority merge, so the lane logic and the merge each end at a register.
// Reset (rst_n, asynchronous) empties both stages; the block is ready at once.
// A stall on the output holds the result and fills the first stage, after which
// in_ready drops until the output transfer happens.

module strahler_tree_compare_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [stc_pkg::BITS_W-1:0]    bits_a,
    input  logic [stc_pkg::BITS_W-1:0]    prefixes_a,
    input  logic [stc_pkg::LEVELS_W-1:0]  ranks_a,
    input  logic [stc_pkg::COUNT_W-1:0]   count_a,
    input  logic [stc_pkg::BITS_W-1:0]    bits_b,
    input  logic [stc_pkg::BITS_W-1:0]    prefixes_b,
    input  logic [stc_pkg::LEVELS_W-1:0]  ranks_b,
    input  logic [stc_pkg::COUNT_W-1:0]   count_b,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [stc_pkg::ORDER_W-1:0]   order
);
    import stc_pkg::*;

    // Levels beyond bit 31 of the field read as zero.
    logic [LEVEL_EXT_W-1:0] ranks_a_ext;
    logic [LEVEL_EXT_W-1:0] ranks_b_ext;

    lane_in_t     [LANES-1:0] lane_ins;
    lane_result_t [LANES-1:0] lane_results;

    // Stage one: per-lane findings.
    lane_result_t [LANES-1:0] lanes_reg;
    logic                     s1_valid_reg;
    logic                     s1_valid_next;

    // Stage two: merged result.
    logic [ORDER_W-1:0] merged_order;
    logic [ORDER_W-1:0] order_reg;
    logic               out_valid_reg;
    logic               out_valid_next;

    logic s2_ready;
    logic s1_ready;
    logic in_fire;
    logic s1_move;

    assign ranks_a_ext = LEVEL_EXT_W'(ranks_a);
    assign ranks_b_ext = LEVEL_EXT_W'(ranks_b);

    // Strings are in use from lane 0 up to the count; a count above the lane
    // total simply marks every lane as present.
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            lane_ins[i].present_a = (count_a > COUNT_W'(i));
            lane_ins[i].present_b = (count_b > COUNT_W'(i));
            lane_ins[i].bits_a    = bits_a[i*STRING_BITS +: STRING_BITS];
            lane_ins[i].mask_a    = prefixes_a[i*STRING_BITS +: STRING_BITS];
            lane_ins[i].level_a   = ranks_a_ext[i*LEVEL_BITS +: LEVEL_BITS];
            lane_ins[i].bits_b    = bits_b[i*STRING_BITS +: STRING_BITS];
            lane_ins[i].mask_b    = prefixes_b[i*STRING_BITS +: STRING_BITS];
            lane_ins[i].level_b   = ranks_b_ext[i*LEVEL_BITS +: LEVEL_BITS];
        end
    end

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        stc_lane u_lane
        (
            .lane_in     (lane_ins[g]),
            .lane_result (lane_results[g])
        );
    end

    stc_merge u_merge
    (
        .lane_results (lanes_reg),
        .order        (merged_order)
    );

    // Each stage advances when the stage after it is empty or is draining.
    assign s2_ready = !out_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;
    assign in_fire  = in_valid && s1_ready;
    assign s1_move  = s1_valid_reg && s2_ready;

    assign s1_valid_next  = in_fire ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
    assign out_valid_next = s2_ready ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            lanes_reg <= lane_results;
        end
        if (s1_move)
        begin
            order_reg <= merged_order;
        end
    end

    assign out_valid = out_valid_reg;
    assign order     = order_reg;

endmodule

/* rtl/core/stc_lane.sv */
`timescale 1ns / 1ps

module stc_lane
(
    input  stc_pkg::lane_in_t     lane_in,
    output stc_pkg::lane_result_t lane_result
);
    import stc_pkg::*;

    str_t shorter;
    str_t xlen;
    str_t first_diff;
    str_t bit_xor;
    str_t window;
    str_t masked;
    str_t diff;
    str_t first_bit;
    logic a_less;
    logic b_less;
    logic a_gt;
    logic b_gt;

    always_comb
    begin
        shorter    = lane_in.mask_a & lane_in.mask_b;
        xlen       = lane_in.mask_a ^ lane_in.mask_b;
        first_diff = xlen & ~(xlen << 1);
        bit_xor    = lane_in.bits_a ^ lane_in.bits_b;
        window     = shorter + first_diff;
        masked     = bit_xor & window;

        a_less = ((lane_in.mask_a < lane_in.mask_b) && (masked == first_diff)) ||
                 ((lane_in.mask_a > lane_in.mask_b) && (masked == '0));
        b_less = ((lane_in.mask_b < lane_in.mask_a) && (masked == first_diff)) ||
                 ((lane_in.mask_b > lane_in.mask_a) && (masked == '0));

        // Isolate the lowest differing bit inside the common prefix.
        diff      = shorter & bit_xor;
        first_bit = diff & (~diff + str_t'(1));
        a_gt      = (diff != '0) && ((lane_in.bits_a & first_bit) != '0);
        b_gt      = (diff != '0) && ((lane_in.bits_b & first_bit) != '0);

        lane_result.decide  = 1'b0;
        lane_result.greater = 1'b0;
        if (lane_in.present_a && !lane_in.present_b)
        begin
            lane_result.decide  = 1'b1;
            lane_result.greater = lane_in.bits_a[0];
        end
        else if (!lane_in.present_a && lane_in.present_b)
        begin
            lane_result.decide  = 1'b1;
            lane_result.greater = !lane_in.bits_b[0];
        end
        else if (lane_in.present_a && lane_in.present_b)
        begin
            if (lane_in.level_a < lane_in.level_b)
            begin
                lane_result.decide  = 1'b1;
                lane_result.greater = lane_in.bits_a[0];
            end
            else if (lane_in.level_a > lane_in.level_b)
            begin
                lane_result.decide  = 1'b1;
                lane_result.greater = !lane_in.bits_b[0];
            end
            else if (a_gt || (!a_less && b_less))
            begin
                lane_result.decide  = 1'b1;
                lane_result.greater = 1'b1;
            end
            else if (b_gt || (a_less && !b_less))
            begin
                lane_result.decide  = 1'b1;
                lane_result.greater = 1'b0;
            end
        end
    end

endmodule

/* rtl/core/stc_merge.sv */
`timescale 1ns / 1ps

module stc_merge
(
    input  stc_pkg::lane_result_t [stc_pkg::LANES-1:0] lane_results,
    output logic [stc_pkg::ORDER_W-1:0]                order
);
    import stc_pkg::*;

    logic found;

    // The lowest lane that decides wins.
    always_comb
    begin
        found = 1'b0;
        order = ORDER_EQUAL;
        for (int i = 0; i < LANES; i++)
        begin
            if (!found && lane_results[i].decide)
            begin
                found = 1'b1;
                order = lane_results[i].greater ? ORDER_GREATER : ORDER_LESS;
            end
        end
    end

endmodule

/* rtl/core/stc_checker.sv */
`timescale 1ns / 1ps

module stc_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [stc_pkg::ORDER_W-1:0] order
);
    import stc_pkg::*;

    // A stalled result stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(order))
    else $error("stalled result changed or vanished");

    // Only the three defined codes ever leave the block.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (order == ORDER_LESS || order == ORDER_EQUAL ||
                       order == ORDER_GREATER))
    else $error("undefined order code");

    // With the output stage empty the pipeline can always take a transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
    else $error("input blocked while output is empty");

    // A transfer into an empty pipeline shows up once it has passed through both stages.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid && !$past(in_valid && in_ready) |=>
            ##1 out_valid)
    else $error("result did not arrive");

endmodule

bind strahler_tree_compare_unit stc_checker u_stc_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .order     (order)
);
